[hdl/insertion_sorter_macros.svh]
// ----------------------------------------------------------------------------
// insertion_sorter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ISRT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define ISRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/isrt_pkg.sv]
// ----------------------------------------------------------------------------
// isrt_pkg
// Types and constants shared by the insertion sorter cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 64;

  // Control broadcast to every cell in the chain.
  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

`default_nettype wire

[hdl/isrt_cell.sv]
// ----------------------------------------------------------------------------
// isrt_cell
// One slot of the sorting chain: holds a value and its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_cell (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire isrt_pkg::cell_ctl_t                  ctl_i,
  input  wire logic                                 lo_gt_i,
  input  wire logic signed [isrt_pkg::DATA_W-1:0]   lo_val_i,
  input  wire logic                                 lo_valid_i,
  input  wire logic signed [isrt_pkg::DATA_W-1:0]   hi_val_i,
  input  wire logic                                 hi_valid_i,
  output logic                                      gt_o,
  output logic signed [isrt_pkg::DATA_W-1:0]        val_o,
  output logic                                      valid_o
);

  logic signed [isrt_pkg::DATA_W-1:0] val_q, val_d;
  logic                               valid_q, valid_d;

  // An empty slot counts as greater than anything, so the new value lands there.
  assign gt_o = !valid_q || (val_q > ctl_i.value);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctl_i.shift) begin
      val_d   = hi_val_i;
      valid_d = hi_valid_i;
    end else if (ctl_i.insert && gt_o) begin
      val_d   = lo_gt_i ? lo_val_i : ctl_i.value;
      valid_d = valid_q || lo_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[hdl/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter
// Sorts each set of signed 32-bit values in a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one value per item in tdata, tlast marks the final
//   value of a set. While filling, one item is taken every cycle; each value
//   drops into its place in the chain in that same cycle, larger entries
//   moving up one cell.
//   When the item with tlast is taken, the chain holds the set in ascending
//   order and the block switches to draining: s_axis_tready goes low and the
//   set comes out of cell 0 on m_axis, one item per cycle while
//   m_axis_tready is high. The first result is offered the cycle after the
//   last input, and input resumes the cycle after the result with tlast is
//   taken. m_axis_tuser flags a set that lost values: values arriving while
//   all CAPACITY cells are full are dropped. A stalled receiver simply holds
//   the chain (the cells are the output register). Reset empties every cell
//   and returns to filling.
// ----------------------------------------------------------------------------
`default_nettype none

`include "insertion_sorter_macros.svh"

module insertion_sorter #(
  parameter int unsigned CAPACITY = isrt_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [isrt_pkg::DATA_W-1:0]   s_axis_tdata_i,   // [31:0] value
  input  wire logic                          s_axis_tlast_i,   // last
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [isrt_pkg::DATA_W-1:0]        m_axis_tdata_o,   // [31:0] sorted_value
  output logic                               m_axis_tlast_o,   // end_of_set
  output logic                               m_axis_tuser_o    // [0] overflow
);

  isrt_pkg::state_e    state_q, state_d;
  logic                dropped_q, dropped_d;
  isrt_pkg::cell_ctl_t ctl;

  logic                               gt_w    [CAPACITY];
  logic signed [isrt_pkg::DATA_W-1:0] val_w   [CAPACITY];
  logic [CAPACITY-1:0]                valid_w;

  logic s_hs, m_hs, full;

  assign full  = valid_w[CAPACITY-1];
  assign s_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_hs  = m_axis_tvalid_o && m_axis_tready_i;

  // Broadcast control: insert while filling and room remains, shift down on pop.
  assign ctl.insert = s_hs && !full;
  assign ctl.shift  = m_hs;
  assign ctl.value  = $signed(s_axis_tdata_i);

  // Chain of cells; cell 0 holds the smallest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               lo_gt, lo_valid, hi_valid;
    logic signed [isrt_pkg::DATA_W-1:0] lo_val, hi_val;

    if (i == 0) begin : g_bottom
      assign lo_gt    = 1'b0;
      assign lo_val   = '0;
      assign lo_valid = 1'b1;
    end else begin : g_lo
      assign lo_gt    = gt_w[i-1];
      assign lo_val   = val_w[i-1];
      assign lo_valid = valid_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign hi_val   = '0;
      assign hi_valid = 1'b0;
    end else begin : g_hi
      assign hi_val   = val_w[i+1];
      assign hi_valid = valid_w[i+1];
    end

    isrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .lo_gt_i    (lo_gt),
      .lo_val_i   (lo_val),
      .lo_valid_i (lo_valid),
      .hi_val_i   (hi_val),
      .hi_valid_i (hi_valid),
      .gt_o       (gt_w[i]),
      .val_o      (val_w[i]),
      .valid_o    (valid_w[i])
    );
  end

  // Sequencer: fill until the last item, then drain the chain.
  always_comb begin
    state_d   = state_q;
    dropped_d = dropped_q;
    unique case (state_q)
      isrt_pkg::ST_FILL: begin
        if (s_hs) begin
          if (full) begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = isrt_pkg::ST_DRAIN;
          end
        end
      end
      isrt_pkg::ST_DRAIN: begin
        if (m_hs && m_axis_tlast_o) begin
          state_d   = isrt_pkg::ST_FILL;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d   = isrt_pkg::ST_FILL;
        dropped_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= isrt_pkg::ST_FILL;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  assign s_axis_tready_o = (state_q == isrt_pkg::ST_FILL);
  assign m_axis_tvalid_o = (state_q == isrt_pkg::ST_DRAIN) && valid_w[0];
  assign m_axis_tdata_o  = val_w[0];
  assign m_axis_tlast_o  = !valid_w[1];
  assign m_axis_tuser_o  = dropped_q;

  // Assertions
  `ISRT_ASSERT(a_one_side, !(s_axis_tready_o && m_axis_tvalid_o), "fill and drain overlap")
  `ISRT_ASSERT(a_packed, ((valid_w >> 1) & ~valid_w) == '0, "chain has a gap")
  `ISRT_ASSERT(a_drain_valid, (state_q != isrt_pkg::ST_DRAIN) || valid_w[0],
    "draining with empty cell 0")
  `ISRT_ASSERT_NEXT(a_empty_after, m_hs && m_axis_tlast_o, valid_w == '0,
    "chain not empty after set")
  `ISRT_ASSERT_NEXT(a_drop_full, !dropped_q, !dropped_q || $past(full),
    "drop flagged with room left")

endmodule

`default_nettype wire

[tb/insertion_sorter_tb.sv]
// ----------------------------------------------------------------------------
// insertion_sorter_tb
// Self-checking bench for the insertion sorter: streams sets of signed values
// in, predicts the ascending output of each set with its own sorted queue,
// and compares every result item field by field under random idling on both
// sides, a long receiver hold-off and sets that overrun the capacity.
// ----------------------------------------------------------------------------

module insertion_sorter_tb;

  localparam int unsigned WORD_W      = isrt_pkg::DATA_W;
  localparam int unsigned CAP         = isrt_pkg::CAPACITY_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_TAIL  = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic signed [WORD_W-1:0] word_t;

  // One expected result item of a drained set.
  typedef struct packed {
    word_t sorted_value;
    logic  end_of_set;
    logic  overflow;
  } sorted_item_t;

  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;

  logic  s_axis_tvalid = 1'b0;
  logic  s_axis_tready;
  word_t s_axis_tdata  = '0;    // [31:0] value
  logic  s_axis_tlast  = 1'b0;  // last
  logic  m_axis_tvalid;
  logic  m_axis_tready = 1'b0;
  logic [WORD_W-1:0] m_axis_tdata;  // [31:0] sorted_value
  logic  m_axis_tlast;              // end_of_set
  logic  m_axis_tuser;              // [0] overflow

  // Predictor state: the current set in ascending order, plus the drop flag.
  word_t        set_store_q[$];
  logic         set_dropped = 1'b0;
  sorted_item_t sorted_expect_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic        hold_go      = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned items_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned sets_closed   = 0;
  int unsigned sets_overflow = 0;

  insertion_sorter #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Insert one accepted value into the predicted set, or flag a drop when full;
  // on the last item, queue the whole set smallest first and empty the store.
  function automatic void predict_sorted(word_t v, logic last);
    int           pos;
    sorted_item_t item;
    if (set_store_q.size() < CAP) begin
      pos = set_store_q.size();
      // Strictly greater entries move up, so equal values keep arrival order;
      // the scan can run all the way down to the first entry.
      while (pos > 0 && set_store_q[pos-1] > v) pos--;
      set_store_q.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (set_store_q[k]) begin
        item.sorted_value = set_store_q[k];
        item.end_of_set   = (k == set_store_q.size() - 1);
        item.overflow     = set_dropped;
        sorted_expect_q.push_back(item);
      end
      sets_closed++;
      if (set_dropped) sets_overflow++;
      set_store_q.delete();
      set_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Watch both handshakes in one process: predict from the input item first,
  // then check the result item taken at the same edge.
  always @(posedge clk_i) begin
    sorted_item_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        predict_sorted(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (sorted_expect_q.size() == 0) begin
          report_mismatch("unexpected result, sorted_value", $signed(m_axis_tdata), 0);
        end else begin
          want = sorted_expect_q.pop_front();
          if (m_axis_tdata !== want.sorted_value)
            report_mismatch("sorted_value", $signed(m_axis_tdata), want.sorted_value);
          if (m_axis_tlast !== want.end_of_set)
            report_mismatch("end_of_set", m_axis_tlast, want.end_of_set);
          if (m_axis_tuser !== want.overflow)
            report_mismatch("overflow", m_axis_tuser, want.overflow);
        end
      end
    end
  end

  // Count down a requested receiver hold-off.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drive the receiver ready: low through reset and any hold-off, random
  // otherwise at the current idle rate.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_go && (hold_left == 0) &&
                       ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item, idling first at the current sender rate; return at the
  // edge where it is taken.
  task automatic send_item(word_t v, logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result item has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sorted_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic word_t random_value();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return word_t'($signed($urandom_range(0, 15)) - 8);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_random_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(random_value(), i == n - 1);
  endtask

  // Extremes as one-item sets.
  task automatic test_single_sets();
    send_item(WORD_MIN, 1'b1);
    send_item(WORD_MAX, 1'b1);
    wait_drained();
  endtask

  // Mixed order with duplicates, a new minimum that must pass the first
  // entry, a strictly falling run and a rising run.
  task automatic test_ordering();
    word_t mixed[9]   = '{0, WORD_MAX, -1, 1, WORD_MIN, 7, 7, -7, 3};
    word_t falling[5] = '{5, 4, 3, 2, 1};
    word_t rising[3]  = '{-2, 0, 2};
    foreach (mixed[i])   send_item(mixed[i], i == 8);
    foreach (falling[i]) send_item(falling[i], i == 4);
    foreach (rising[i])  send_item(rising[i], i == 2);
    wait_drained();
  endtask

  // Fill the store exactly, then overrun it with the last item itself
  // dropped, then check the drop flag clears for the next set.
  task automatic test_capacity();
    send_random_set(CAP);
    send_random_set(CAP + 2);
    send_item(WORD_MAX, 1'b0);
    send_item(WORD_MIN, 1'b1);
    wait_drained();
  endtask

  // Stall the receiver while a set drains and keep offering the next set,
  // so the input side backs up behind the held chain.
  task automatic test_backpressure();
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    send_random_set(6);
    send_random_set(5);
    send_random_set(8);
    wait_drained();
  endtask

  // Random sets, mostly short, a few long ones; the last set is cut to the
  // item budget.
  task automatic test_random_sets(int unsigned src_pct, int unsigned snk_pct,
                                  int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at      = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)       n = $urandom_range(1, 8);
      else if (pick < 18)  n = $urandom_range(9, 24);
      else if (pick == 18) n = CAP;
      else                 n = $urandom_range(CAP + 1, CAP + 4);
      if (n > stop_at - items_sent) n = stop_at - items_sent;
      send_random_set(n);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sets();
    test_ordering();
    test_capacity();
    test_backpressure();
    test_random_sets(34, 65, 30);
    test_random_sets(65, 34, 30);
    test_random_sets(0, 0, 30);

    repeat (DRAIN_TAIL) @(posedge clk_i);
    $display("covered %0d sets (%0d overrun) from %0d items, %0d result items checked",
             sets_closed, sets_overflow, items_taken, results_seen);
    $display("idle mixes 34/65, 65/34 and none, plus a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/isrt_pkg.sv
hdl/isrt_cell.sv
hdl/insertion_sorter.sv
tb/insertion_sorter_tb.sv
